>>> rtl/rfvl_pkg.sv
// Package for the range frequent values list: sizes, word type, codes,
// state encoding and the control structs shared by the cells and the core.
// No dependencies.
package rfvl_pkg;

  localparam int DEPTH    = 16;
  localparam int AW       = $clog2(DEPTH);
  localparam int SPAN_MAX = 16;
  localparam int CNT_W    = $clog2(SPAN_MAX + 1);

  localparam logic [4:0] MAX_COUNT = 5'd17;

  typedef logic signed [31:0] word_t;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_FOUND = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_COND  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SETTLE,
    S_DRAIN,
    S_FINAL,
    S_ERR
  } state_e;

  typedef struct packed {
    logic take_new;
    logic take_nb;
  } entry_ctl_t;

  typedef struct packed {
    logic clear;
    logic drain;
  } sort_ctl_t;

endpackage

>>> rtl/rfvl_entry_cell.sv
// One storage cell of the entry chain: holds an entry, takes a new value
// or its lower neighbor's entry on an add. Depends on rfvl_pkg.
module rfvl_entry_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfvl_pkg::entry_ctl_t ctl_i,
  input  rfvl_pkg::word_t     value_i,
  input  rfvl_pkg::word_t     nb_i,
  output rfvl_pkg::word_t     entry_o
);

  rfvl_pkg::word_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.take_new) begin
      entry_d = value_i;
    end else if (ctl_i.take_nb) begin
      entry_d = nb_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/rfvl_sort_cell.sv
// One cell of the systolic insertion sorter: keeps the smaller word, passes
// the larger to the next cell, and shifts toward the head while draining.
// Depends on rfvl_pkg.
module rfvl_sort_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfvl_pkg::sort_ctl_t ctl_i,
  input  logic                in_valid_i,
  input  rfvl_pkg::word_t     in_val_i,
  input  logic                nb_valid_i,
  input  rfvl_pkg::word_t     nb_val_i,
  output logic                valid_o,
  output rfvl_pkg::word_t     val_o,
  output logic                pass_valid_o,
  output rfvl_pkg::word_t     pass_val_o
);

  logic            valid_q, valid_d;
  logic            pass_valid_q, pass_valid_d;
  rfvl_pkg::word_t val_q, val_d;
  rfvl_pkg::word_t pass_q, pass_d;

  always_comb begin
    valid_d      = valid_q;
    val_d        = val_q;
    pass_valid_d = 1'b0;
    pass_d       = pass_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.drain) begin
      valid_d = nb_valid_i;
      val_d   = nb_val_i;
    end else if (in_valid_i) begin
      if (!valid_q) begin
        valid_d = 1'b1;
        val_d   = in_val_i;
      end else if (in_val_i < val_q) begin
        val_d        = in_val_i;
        pass_valid_d = 1'b1;
        pass_d       = val_q;
      end else begin
        pass_valid_d = 1'b1;
        pass_d       = in_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      pass_valid_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      pass_valid_q <= pass_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pass_q <= pass_d;
  end

  assign valid_o      = valid_q;
  assign val_o        = val_q;
  assign pass_valid_o = pass_valid_q;
  assign pass_val_o   = pass_q;

endmodule

>>> rtl/range_frequent_values_list_core.sv
// Range frequent values list, top level: entry chain, sorter chain, control.
// Depends on rfvl_pkg, rfvl_entry_cell and rfvl_sort_cell.
//
// On an add word the entry cells from the cursor up shift by one place and the
// cell at the cursor takes the value. A query over n entries (n = right - left
// + 1) streams the range into a 16-cell insertion sorter, lets it settle, then
// drains it head first while counting runs, and ends with the final word. A
// failed query condition skips the sorter and gives a single status word.
// A new input word is taken only when the previous one is done; a finished
// result may still wait in the output register. No clearing pass after reset.
module range_frequent_values_list_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] value, [35:32] left_index, [39:36] right_index, [44:40] min_count
  input  logic [47:0] s_axis_tdata_i,
  // [0] cmd
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] found_value
  output logic [31:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  localparam int AW    = rfvl_pkg::AW;
  localparam int NS    = rfvl_pkg::SPAN_MAX;
  localparam int CNT_W = rfvl_pkg::CNT_W;

  // input fields
  rfvl_pkg::word_t in_value;
  logic [3:0]      in_lo, in_hi;
  logic [4:0]      in_min, min_sat;
  logic [3:0]      span;
  logic            cond_fail;
  logic            in_fire, add_fire, q_fire;

  assign in_value = s_axis_tdata_i[31:0];
  assign in_lo    = s_axis_tdata_i[35:32];
  assign in_hi    = s_axis_tdata_i[39:36];
  assign in_min   = s_axis_tdata_i[44:40];
  assign min_sat  = (in_min > rfvl_pkg::MAX_COUNT) ? rfvl_pkg::MAX_COUNT : in_min;
  assign span     = in_hi - in_lo;
  assign cond_fail = (in_lo > in_hi) || (int'(in_hi) >= rfvl_pkg::DEPTH) ||
                     ((span != 4'd0) &&
                      ({min_sat, 1'b0} < ({2'b00, span} - 6'd1)));

  rfvl_pkg::state_e state_q, state_d;

  assign s_axis_tready_o = (state_q == rfvl_pkg::S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign add_fire = in_fire && (s_axis_tuser_i == rfvl_pkg::CMD_ADD);
  assign q_fire   = in_fire && (s_axis_tuser_i == rfvl_pkg::CMD_QUERY);

  // entry chain
  logic [AW-1:0]   cursor_q, cursor_d;
  rfvl_pkg::word_t entry_w [rfvl_pkg::DEPTH];

  assign cursor_d = (add_fire && (cursor_q != AW'(rfvl_pkg::DEPTH - 1))) ?
                    cursor_q + 1'b1 : cursor_q;

  for (genvar i = 0; i < rfvl_pkg::DEPTH; i++) begin : g_entry
    rfvl_pkg::entry_ctl_t ectl;
    rfvl_pkg::word_t      nb;
    assign ectl.take_new = add_fire && (AW'(i) == cursor_q);
    assign ectl.take_nb  = add_fire && (AW'(i) > cursor_q);
    if (i == 0) begin : g_first
      assign nb = '0;
    end else begin : g_rest
      assign nb = entry_w[i-1];
    end
    rfvl_entry_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ectl),
      .value_i (in_value),
      .nb_i    (nb),
      .entry_o (entry_w[i])
    );
  end

  // sorter chain
  rfvl_pkg::sort_ctl_t sctl;
  logic                feed_valid;
  logic [NS-1:0]       sv_valid, sp_valid;
  rfvl_pkg::word_t     sv_val [NS];
  rfvl_pkg::word_t     sp_val [NS];
  logic [AW-1:0]       rd_q, rd_d;

  for (genvar i = 0; i < NS; i++) begin : g_sort
    logic            in_v, nb_v;
    rfvl_pkg::word_t in_d, nb_d;
    if (i == 0) begin : g_head
      assign in_v = feed_valid;
      assign in_d = entry_w[rd_q];
    end else begin : g_body
      assign in_v = sp_valid[i-1];
      assign in_d = sp_val[i-1];
    end
    if (i == NS - 1) begin : g_tail
      assign nb_v = 1'b0;
      assign nb_d = '0;
    end else begin : g_mid
      assign nb_v = sv_valid[i+1];
      assign nb_d = sv_val[i+1];
    end
    rfvl_sort_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (sctl),
      .in_valid_i   (in_v),
      .in_val_i     (in_d),
      .nb_valid_i   (nb_v),
      .nb_val_i     (nb_d),
      .valid_o      (sv_valid[i]),
      .val_o        (sv_val[i]),
      .pass_valid_o (sp_valid[i]),
      .pass_val_o   (sp_val[i])
    );
  end

  // control and run counting
  logic [CNT_W-1:0] cnt_q, cnt_d, n_q, n_d;
  logic [4:0]       need_q, need_d, run_q, run_d;
  logic             cur_valid_q, cur_valid_d, pend_valid_q, pend_valid_d;
  rfvl_pkg::word_t  cur_q, cur_d, pend_q, pend_d;
  logic             out_free, qual;

  logic             emit, emit_last;
  rfvl_pkg::word_t  emit_val;
  rfvl_pkg::status_e emit_status;

  logic              out_valid_q;
  rfvl_pkg::word_t   out_data_q;
  rfvl_pkg::status_e out_status_q;
  logic              out_last_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign qual     = cur_valid_q && (run_q >= need_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rfvl_pkg::S_IDLE: begin
        if (q_fire) begin
          state_d = cond_fail ? rfvl_pkg::S_ERR : rfvl_pkg::S_LOAD;
        end
      end
      rfvl_pkg::S_LOAD: begin
        if (cnt_q == n_q - 1'b1) begin
          state_d = rfvl_pkg::S_SETTLE;
        end
      end
      rfvl_pkg::S_SETTLE: begin
        if (cnt_q == CNT_W'(NS - 1)) begin
          state_d = rfvl_pkg::S_DRAIN;
        end
      end
      rfvl_pkg::S_DRAIN: begin
        if (out_free && (cnt_q == n_q)) begin
          state_d = rfvl_pkg::S_FINAL;
        end
      end
      rfvl_pkg::S_FINAL, rfvl_pkg::S_ERR: begin
        if (out_free) begin
          state_d = rfvl_pkg::S_IDLE;
        end
      end
      default: state_d = rfvl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sctl         = '0;
    feed_valid   = 1'b0;
    rd_d         = rd_q;
    cnt_d        = cnt_q;
    n_d          = n_q;
    need_d       = need_q;
    run_d        = run_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    emit         = 1'b0;
    emit_val     = '0;
    emit_status  = rfvl_pkg::STAT_FOUND;
    emit_last    = 1'b0;
    case (state_q)
      rfvl_pkg::S_IDLE: begin
        if (q_fire) begin
          sctl.clear   = 1'b1;
          rd_d         = AW'(in_lo);
          n_d          = CNT_W'(span) + 1'b1;
          need_d       = min_sat;
          cnt_d        = '0;
          cur_valid_d  = 1'b0;
          pend_valid_d = 1'b0;
        end
      end
      rfvl_pkg::S_LOAD: begin
        feed_valid = 1'b1;
        rd_d       = rd_q + 1'b1;
        cnt_d      = (cnt_q == n_q - 1'b1) ? '0 : cnt_q + 1'b1;
      end
      rfvl_pkg::S_SETTLE: begin
        cnt_d = (cnt_q == CNT_W'(NS - 1)) ? '0 : cnt_q + 1'b1;
      end
      rfvl_pkg::S_DRAIN: begin
        if (out_free) begin
          if ((cnt_q < n_q) && cur_valid_q && (sv_val[0] == cur_q)) begin
            run_d = run_q + 1'b1;
          end else begin
            if (qual) begin
              emit         = pend_valid_q;
              emit_val     = pend_q;
              pend_d       = cur_q;
              pend_valid_d = 1'b1;
            end
            cur_d       = sv_val[0];
            cur_valid_d = (cnt_q < n_q);
            run_d       = 5'd1;
          end
          if (cnt_q < n_q) begin
            sctl.drain = 1'b1;
            cnt_d      = cnt_q + 1'b1;
          end
        end
      end
      rfvl_pkg::S_FINAL: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          emit_val    = pend_valid_q ? pend_q : '0;
          emit_status = pend_valid_q ? rfvl_pkg::STAT_FOUND : rfvl_pkg::STAT_NONE;
        end
      end
      rfvl_pkg::S_ERR: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          emit_status = rfvl_pkg::STAT_COND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rfvl_pkg::S_IDLE;
      cursor_q     <= '0;
      cnt_q        <= '0;
      cur_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      cnt_q        <= cnt_d;
      cur_valid_q  <= cur_valid_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    n_q    <= n_d;
    need_q <= need_d;
    run_q  <= run_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
    if (emit) begin
      out_data_q   <= emit_val;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sp_valid[NS-1])
    else $error("sorter chain overflow");

  a_sorted_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfvl_pkg::S_DRAIN) && (cnt_q == '0) |-> ($countones(sv_valid) == int'(n_q)))
    else $error("sorter holds wrong number of words");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfvl_pkg::S_DRAIN) && (cnt_q < n_q) |-> sv_valid[0])
    else $error("sorter head empty while draining");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != rfvl_pkg::STAT_FOUND) |->
      m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("status word not final or not zero");
`endif

endmodule

>>> test/range_frequent_values_list_core_test.sv
// Testbench for range_frequent_values_list_core: stream stimulus, a behavioral
// predictor of the entry store and the frequency query, and a result scoreboard.
// Depends on rfvl_pkg and the core RTL.
module range_frequent_values_list_core_test;

  localparam int AW = rfvl_pkg::AW;

  typedef struct {
    rfvl_pkg::word_t   value;
    rfvl_pkg::status_e status;
    logic              last;
  } freq_result_t;

  typedef struct {
    rfvl_pkg::cmd_e    cmd;
    rfvl_pkg::word_t   value;
    logic [3:0]        lo;
    logic [3:0]        hi;
    logic [4:0]        cnt;
    logic              typed;
    rfvl_pkg::word_t   exp_value;
    rfvl_pkg::status_e exp_status;
  } stim_row_t;

  localparam int NUM_DIRECTED = 21;
  localparam int NUM_RANDOM   = 130;
  localparam int NUM_CALM     = 30;
  localparam int NUM_PRESSED  = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  range_frequent_values_list_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  rfvl_pkg::word_t mirror_entries [rfvl_pkg::DEPTH];
  logic [AW-1:0]   mirror_cursor;
  freq_result_t    pending_results [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int adds_sent      = 0;
  int queries_sent   = 0;
  int cond_queries   = 0;
  int empty_queries  = 0;
  int found_values   = 0;

  logic calm          = 1'b0;
  logic hold_request  = 1'b0;
  logic hold_done     = 1'b0;
  logic stimulus_done = 1'b0;

  stim_row_t directed_rows [NUM_DIRECTED];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  function automatic void store_add(input rfvl_pkg::word_t value);
    for (int i = rfvl_pkg::DEPTH - 1; i > int'(mirror_cursor); i--)
      mirror_entries[i] = mirror_entries[i - 1];
    mirror_entries[mirror_cursor] = value;
    if (mirror_cursor != AW'(rfvl_pkg::DEPTH - 1))
      mirror_cursor++;
  endfunction

  function automatic void frequent_values(input logic [3:0] lo, input logic [3:0] hi,
                                          input logic [4:0] cnt);
    rfvl_pkg::word_t span_vals [rfvl_pkg::SPAN_MAX];
    rfvl_pkg::word_t t;
    int              n, need, run, i, k;
    need = (cnt > rfvl_pkg::MAX_COUNT) ? int'(rfvl_pkg::MAX_COUNT) : int'(cnt);
    if (lo > hi || int'(hi) >= rfvl_pkg::DEPTH || 2 * need < int'(hi) - int'(lo) - 1) begin
      pending_results.push_back('{value: '0, status: rfvl_pkg::STAT_COND, last: 1'b1});
      cond_queries++;
      return;
    end
    n = int'(hi) - int'(lo) + 1;
    for (int a = 0; a < n; a++)
      span_vals[a] = mirror_entries[int'(lo) + a];
    for (int a = 0; a < n; a++)
      for (int b = a + 1; b < n; b++)
        if (span_vals[a] > span_vals[b]) begin
          t = span_vals[a];
          span_vals[a] = span_vals[b];
          span_vals[b] = t;
        end
    i = 0;
    k = 0;
    while (i < n) begin
      run = 1;
      while (i + run < n && span_vals[i + run] == span_vals[i])
        run++;
      if (run >= need) begin
        pending_results.push_back('{value: span_vals[i], status: rfvl_pkg::STAT_FOUND,
                                    last: 1'b0});
        k++;
      end
      i += run;
    end
    if (k == 0) begin
      pending_results.push_back('{value: '0, status: rfvl_pkg::STAT_NONE, last: 1'b1});
      empty_queries++;
    end else begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic offer_word(input rfvl_pkg::cmd_e cmd, input rfvl_pkg::word_t value,
                            input logic [3:0] lo, input logic [3:0] hi,
                            input logic [4:0] cnt);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, cnt, hi, lo, value};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (cmd == rfvl_pkg::CMD_ADD)
      adds_sent++;
    else
      queries_sent++;
  endtask

  task automatic maybe_gap();
    int gap;
    gap = $urandom_range(1, 4);
    if (!calm && $urandom_range(0, 9) < 3) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic rfvl_pkg::word_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd1;
      4: return 32'sd0;
      5: return 32'sd5;
      default: return rfvl_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic random_word();
    logic [3:0] lo, hi;
    logic [4:0] cnt;
    int         need_min;
    if ($urandom_range(0, 9) < 3) begin
      offer_word(rfvl_pkg::CMD_ADD, pick_value(), 4'($urandom), 4'($urandom), 5'($urandom));
      store_add(rfvl_pkg::word_t'(s_axis_tdata_i[31:0]));
      return;
    end
    case ($urandom_range(0, 19))
      0, 1: begin
        // left above right
        hi  = 4'($urandom_range(0, 14));
        lo  = 4'($urandom_range(int'(hi) + 1, 15));
        cnt = 5'($urandom);
      end
      2: begin
        // count too small for the span
        lo  = 4'($urandom_range(0, 12));
        hi  = 4'($urandom_range(int'(lo) + 3, 15));
        cnt = 5'($urandom_range(0, (int'(hi) - int'(lo) - 2) / 2));
      end
      3: begin
        lo  = 4'($urandom);
        hi  = 4'($urandom);
        cnt = 5'($urandom);
      end
      default: begin
        lo       = 4'($urandom);
        hi       = 4'($urandom_range(int'(lo), 15));
        need_min = (int'(hi) - int'(lo)) / 2;
        cnt      = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(need_min, 31))
                                               : 5'($urandom_range(need_min, need_min + 2));
      end
    endcase
    offer_word(rfvl_pkg::CMD_QUERY, rfvl_pkg::word_t'($urandom), lo, hi, cnt);
    frequent_values(lo, hi, cnt);
  endtask

  initial begin
    directed_rows = '{
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd0, 1'b1, 32'sd0, rfvl_pkg::STAT_COND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd7, 1'b1, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd17, 1'b1, 32'sd0, rfvl_pkg::STAT_NONE},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd31, 1'b1, 32'sd0, rfvl_pkg::STAT_NONE},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd5, 4'd4, 5'd3, 1'b1, 32'sd0, rfvl_pkg::STAT_COND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd0, 5'd0, 1'b1, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, 32'sh7FFF_FFFF, 4'd0, 4'd0, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, 32'sh8000_0000, 4'd15, 4'd15, 5'd31, 1'b0, 32'sd0,
        rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, -32'sd1, 4'd0, 4'd0, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, 32'sd1, 4'd0, 4'd0, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, 32'sh8000_0000, 4'd0, 4'd0, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, -32'sd1, 4'd0, 4'd0, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd5, 5'd2, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd3, 5'd1, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd1, 1'b1, 32'sd0, rfvl_pkg::STAT_COND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd15, 4'd0, 5'd0, 1'b1, 32'sd0, rfvl_pkg::STAT_COND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd6, 4'd15, 5'd4, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd8, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd2, 4'd3, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_ADD, 32'sh1234_5678, 4'd0, 4'd0, 5'd0, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND},
      '{rfvl_pkg::CMD_QUERY, 32'sd0, 4'd0, 4'd15, 5'd16, 1'b0, 32'sd0, rfvl_pkg::STAT_FOUND}
    };
    for (int i = 0; i < rfvl_pkg::DEPTH; i++)
      mirror_entries[i] = '0;
    mirror_cursor = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      offer_word(directed_rows[r].cmd, directed_rows[r].value, directed_rows[r].lo,
                 directed_rows[r].hi, directed_rows[r].cnt);
      if (directed_rows[r].cmd == rfvl_pkg::CMD_ADD) begin
        store_add(directed_rows[r].value);
      end else if (directed_rows[r].typed) begin
        pending_results.push_back('{value: directed_rows[r].exp_value,
                                    status: directed_rows[r].exp_status, last: 1'b1});
        if (directed_rows[r].exp_status == rfvl_pkg::STAT_COND)
          cond_queries++;
        else if (directed_rows[r].exp_status == rfvl_pkg::STAT_NONE)
          empty_queries++;
      end else begin
        frequent_values(directed_rows[r].lo, directed_rows[r].hi, directed_rows[r].cnt);
      end
      maybe_gap();
    end

    // let the block run dry before the random part
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    hold_request = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - NUM_CALM)
        calm = 1'b1;
      random_word();
      if (n >= NUM_PRESSED)
        maybe_gap();
    end
    s_axis_tvalid_i <= 1'b0;
    stimulus_done = 1'b1;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("covered %0d adds and %0d queries (%0d failed conditions, %0d with no value)",
             adds_sent, queries_sent, cond_queries, empty_queries);
    $display("checked %0d result words, %0d of them found values, %0d mismatches",
             results_seen, found_values, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** range_frequent_values_list_core: PASSED **");
    end else begin
      $display("** range_frequent_values_list_core: FAILED **");
    end
    $finish;
  end

  // result side: scoreboard, stall bursts and one long hold-off
  initial begin
    freq_result_t want;
    int           hold_left, stall_left;
    logic         bursty;
    hold_left  = 0;
    stall_left = 0;
    bursty     = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, value", longint'($signed(m_axis_tdata_o)), 0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata_o !== want.value)
            report_mismatch("found_value", longint'($signed(m_axis_tdata_o)),
                            longint'(want.value));
          if (m_axis_tuser_o !== want.status)
            report_mismatch("status", longint'(m_axis_tuser_o), longint'(want.status));
          if (m_axis_tlast_o !== want.last)
            report_mismatch("last", longint'(m_axis_tlast_o), longint'(want.last));
          if (want.status == rfvl_pkg::STAT_FOUND)
            found_values++;
        end
        results_seen++;
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if ($urandom_range(0, 63) == 0)
        bursty = ~bursty;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && bursty && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout, stimulus done %0d, %0d results outstanding",
             stimulus_done, pending_results.size());
    $display("** range_frequent_values_list_core: FAILED **");
    $finish;
  end

endmodule
